FILE: rtl/psis_pkg.sv
// Shared constants, command and status codes, and interface types for the posting seek block.
package psis_pkg;

    // Sizes of the list, the index and a location
    localparam int LOC_BITS    = 32;
    localparam int MAX_POSTS   = 4096;
    localparam int SYNC_POINTS = 1024;
    localparam int PIDX_BITS   = $clog2(MAX_POSTS);
    localparam int CNT_BITS    = $clog2(MAX_POSTS + 1);
    localparam int SYNC_BITS   = (SYNC_POINTS > 1) ? $clog2(SYNC_POINTS) : 1;
    localparam int LB_BITS     = 5;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BITS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START    = 1'b1;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // One index bucket entry
    typedef struct packed {
        logic                 valid;
        logic [LOC_BITS-1:0]  loc;
        logic [PIDX_BITS-1:0] off;
    } sync_entry_t;

    // Shared add / shift / compare unit
    typedef struct packed {
        logic [LOC_BITS-1:0] a;
        logic [LOC_BITS-1:0] b;
        logic [LOC_BITS-1:0] c;
        logic [LB_BITS-1:0]  lb;
    } alu_req_t;

    typedef struct packed {
        logic [LOC_BITS-1:0] sum;
        logic [LOC_BITS-1:0] shr;
        logic                ge;
    } alu_resp_t;

    // Memory requests
    typedef struct packed {
        logic                 we;
        logic [PIDX_BITS-1:0] addr;
        logic [31:0]          wdata;
    } dmem_req_t;

    typedef struct packed {
        logic                 we;
        logic [SYNC_BITS-1:0] addr;
        sync_entry_t          wdata;
    } smem_req_t;

endpackage

FILE: rtl/psis_ram.sv
// Generic single-port RAM with registered read data.
module psis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/psis_alu.sv
// Shared add, bucket shift and compare unit used by append and seek.
module psis_alu
    import psis_pkg::*;
(
    input  alu_req_t  req,
    output alu_resp_t resp
);

    logic [LOC_BITS-1:0] sum;

    // Add, then take the bucket number and compare against the target
    always_comb
    begin
        sum      = req.a + req.b;
        resp.sum = sum;
        resp.shr = sum >> req.lb;
        resp.ge  = (sum >= req.c);
    end

endmodule

FILE: rtl/psis_ctrl.sv
// Command sequencer: clear pass, append, bucket scan and delta walk, output register.
module psis_ctrl
    import psis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [31:0]          delta,
    input  logic [LOC_BITS-1:0]  target,
    input  logic [LB_BITS-1:0]   low_bits,
    input  logic [LOC_BITS-1:0]  start_location,
    output alu_req_t             alu_req,
    input  alu_resp_t            alu_resp,
    output dmem_req_t            dmem_req,
    input  logic [31:0]          delta_rdata,
    output smem_req_t            smem_req,
    input  sync_entry_t          sync_rdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [LOC_BITS-1:0]  location,
    output logic [PIDX_BITS-1:0] post_index
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_CLR        = 11'b000_0000_0010,
        S_APP        = 11'b000_0000_0100,
        S_APP_CHK    = 11'b000_0000_1000,
        S_SEEK       = 11'b000_0001_0000,
        S_SYNC_RD    = 11'b000_0010_0000,
        S_SYNC_CHK   = 11'b000_0100_0000,
        S_WALK_FIRST = 11'b000_1000_0000,
        S_WALK_RD    = 11'b001_0000_0000,
        S_WALK_ADD   = 11'b010_0000_0000,
        S_OUT        = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  post_count_reg, post_count_next;
    logic [LOC_BITS-1:0]  running_reg, running_next;
    logic [SYNC_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic                 first_reg, first_next;
    logic                 out_valid_reg, out_valid_next;

    logic [LOC_BITS-1:0]  tgt_reg, tgt_next;
    logic [31:0]          delta_reg, delta_next;
    logic [LOC_BITS-1:0]  loc_reg, loc_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [SYNC_BITS-1:0] bucket_reg, bucket_next;
    logic [1:0]           st_reg, st_next;
    logic [1:0]           out_status_reg;
    logic [LOC_BITS-1:0]  out_loc_reg;
    logic [PIDX_BITS-1:0] out_idx_reg;
    logic                 out_load;
    logic                 walk_ok;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign location   = out_loc_reg;
    assign post_index = out_idx_reg;

    // Current post still inside the target bucket and inside the list
    assign walk_ok = (alu_resp.shr <= LOC_BITS'(bucket_reg)) && (idx_reg < post_count_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        post_count_next = post_count_reg;
        running_next    = running_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        first_next      = first_reg;
        tgt_next        = tgt_reg;
        delta_next      = delta_reg;
        loc_next        = loc_reg;
        idx_next        = idx_reg;
        bucket_next     = bucket_reg;
        st_next         = st_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        alu_req.a  = loc_reg;
        alu_req.b  = '0;
        alu_req.c  = tgt_reg;
        alu_req.lb = low_bits;

        dmem_req.we    = 1'b0;
        dmem_req.addr  = idx_reg[PIDX_BITS-1:0];
        dmem_req.wdata = delta_reg;

        smem_req.we    = 1'b0;
        smem_req.addr  = bucket_reg;
        smem_req.wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tgt_next   = target;
                    delta_next = delta;
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            post_count_next = '0;
                            running_next    = start_location;
                            loc_next        = start_location;
                            idx_next        = '0;
                            st_next         = ST_OK;
                            clr_cnt_next    = '0;
                            clr_reply_next  = 1'b1;
                            state_next      = S_CLR;
                        end
                        CMD_APPEND:
                        begin
                            if (post_count_reg >= CNT_BITS'(MAX_POSTS))
                            begin
                                st_next    = ST_FULL;
                                loc_next   = '0;
                                idx_next   = '0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                idx_next   = post_count_reg;
                                state_next = S_APP;
                            end
                        end
                        CMD_SEEK:
                        begin
                            state_next = S_SEEK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                smem_req.we   = 1'b1;
                smem_req.addr = clr_cnt_reg;
                if (clr_cnt_reg == SYNC_BITS'(SYNC_POINTS - 1))
                begin
                    state_next = clr_reply_reg ? S_OUT : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_APP:
            begin
                alu_req.a       = running_reg;
                alu_req.b       = delta_reg;
                dmem_req.we     = 1'b1;
                running_next    = alu_resp.sum;
                loc_next        = alu_resp.sum;
                post_count_next = post_count_reg + 1'b1;
                if (alu_resp.shr >= LOC_BITS'(SYNC_POINTS))
                begin
                    st_next    = ST_RANGE;
                    state_next = S_OUT;
                end
                else
                begin
                    st_next       = ST_OK;
                    bucket_next   = alu_resp.shr[SYNC_BITS-1:0];
                    smem_req.addr = alu_resp.shr[SYNC_BITS-1:0];
                    state_next    = S_APP_CHK;
                end
            end
            S_APP_CHK:
            begin
                // Fill the bucket with its first post only
                if (!sync_rdata.valid)
                begin
                    smem_req.we          = 1'b1;
                    smem_req.wdata.valid = 1'b1;
                    smem_req.wdata.loc   = loc_reg;
                    smem_req.wdata.off   = idx_reg[PIDX_BITS-1:0];
                end
                state_next = S_OUT;
            end
            S_SEEK:
            begin
                alu_req.a = tgt_reg;
                if (alu_resp.shr >= LOC_BITS'(SYNC_POINTS))
                begin
                    st_next    = ST_RANGE;
                    loc_next   = '0;
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    bucket_next   = alu_resp.shr[SYNC_BITS-1:0];
                    smem_req.addr = alu_resp.shr[SYNC_BITS-1:0];
                    first_next    = 1'b1;
                    state_next    = S_SYNC_CHK;
                end
            end
            S_SYNC_RD:
            begin
                state_next = S_SYNC_CHK;
            end
            S_SYNC_CHK:
            begin
                if (sync_rdata.valid)
                begin
                    loc_next   = sync_rdata.loc;
                    idx_next   = CNT_BITS'(sync_rdata.off);
                    st_next    = ST_OK;
                    state_next = first_reg ? S_WALK_FIRST : S_OUT;
                end
                else
                begin
                    first_next = 1'b0;
                    if (bucket_reg == SYNC_BITS'(SYNC_POINTS - 1))
                    begin
                        st_next    = ST_NOT_FOUND;
                        loc_next   = '0;
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + 1'b1;
                        state_next  = S_SYNC_RD;
                    end
                end
            end
            S_WALK_FIRST:
            begin
                if (!walk_ok)
                begin
                    st_next    = ST_NOT_FOUND;
                    loc_next   = '0;
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (alu_resp.ge)
                begin
                    st_next    = ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                if (!walk_ok)
                begin
                    st_next    = ST_NOT_FOUND;
                    loc_next   = '0;
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WALK_ADD;
                end
            end
            S_WALK_ADD:
            begin
                alu_req.b = delta_rdata;
                loc_next  = alu_resp.sum;
                if (alu_resp.ge)
                begin
                    st_next    = ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_OUT:
            begin
                // Hand the word over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // Control registers; reset starts with a clearing pass over the index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            post_count_reg <= '0;
            running_reg    <= '0;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            post_count_reg <= post_count_next;
            running_reg    <= running_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_reply_reg  <= clr_reply_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg    <= tgt_next;
        delta_reg  <= delta_next;
        loc_reg    <= loc_next;
        idx_reg    <= idx_next;
        bucket_reg <= bucket_next;
        st_reg     <= st_next;
        if (out_load)
        begin
            out_status_reg <= st_reg;
            out_loc_reg    <= loc_reg;
            out_idx_reg    <= idx_reg[PIDX_BITS-1:0];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        post_count_reg <= CNT_BITS'(MAX_POSTS))
        else $error("post count beyond list depth");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_ADD) |-> (idx_reg < post_count_reg))
        else $error("delta read past the end of the list");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result left while output register was full");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside the output state");
`endif

endmodule

FILE: rtl/posting_sync_index_seek_top.sv
// Top level of the posting list seek block: configuration registers, stores and sequencer.
//
//  channel   direction  handshake            word
//  input     in         in_valid / in_ready  cmd, delta, target
//  output    out        out_valid / out_ready status, location, post_index
//  config    in         cfg_we               cfg_index, cfg_data
//
// Every command runs to its result before the next word is taken; a seek sums deltas in a
// filled target bucket, or scans empty buckets forward to the first post of a filled one,
// using the single-port index and delta memories and one shared add/shift/compare unit.
// After reset a clearing pass over the index runs before in_ready rises.
// A finished result waits in the output register and the next word is taken meanwhile;
// a second result holds the sequencer, with in_ready low, until out_ready frees the register.
module posting_sync_index_seek_top
    import psis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [31:0]              delta,
    input  logic [LOC_BITS-1:0]      target,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [LOC_BITS-1:0]      location,
    output logic [PIDX_BITS-1:0]     post_index,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [LB_BITS-1:0]  low_bits_reg;
    logic [LOC_BITS-1:0] start_location_reg;

    alu_req_t    alu_req;
    alu_resp_t   alu_resp;
    dmem_req_t   dmem_req;
    smem_req_t   smem_req;
    logic [31:0] delta_rdata;
    logic [$bits(sync_entry_t)-1:0] sync_rdata_raw;
    sync_entry_t sync_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bits_reg       <= LB_BITS'(8);
            start_location_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_BITS: low_bits_reg       <= cfg_data[LB_BITS-1:0];
                CFG_START:    start_location_reg <= cfg_data[LOC_BITS-1:0];
            endcase
        end
    end

    // Delta store
    psis_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POSTS)
    ) u_delta_ram (
        .clk   (clk),
        .we    (dmem_req.we),
        .addr  (dmem_req.addr),
        .wdata (dmem_req.wdata),
        .rdata (delta_rdata)
    );

    // Sync point index
    psis_ram #(
        .WIDTH ($bits(sync_entry_t)),
        .DEPTH (SYNC_POINTS)
    ) u_sync_ram (
        .clk   (clk),
        .we    (smem_req.we),
        .addr  (smem_req.addr),
        .wdata (smem_req.wdata),
        .rdata (sync_rdata_raw)
    );

    assign sync_rdata = sync_rdata_raw;

    psis_alu u_alu (
        .req  (alu_req),
        .resp (alu_resp)
    );

    psis_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .delta          (delta),
        .target         (target),
        .low_bits       (low_bits_reg),
        .start_location (start_location_reg),
        .alu_req        (alu_req),
        .alu_resp       (alu_resp),
        .dmem_req       (dmem_req),
        .delta_rdata    (delta_rdata),
        .smem_req       (smem_req),
        .sync_rdata     (sync_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .location       (location),
        .post_index     (post_index)
    );

endmodule

FILE: tb/sv/posting_sync_index_seek_top_tb.sv
// Self-checking testbench for the posting list seek block: directed, full-list, stall and random tests.
`timescale 1ns / 1ps

module posting_sync_index_seek_top_tb;
    import psis_pkg::*;

    // Command code that the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int IDLE_PAUSE  = 32;
    localparam int TAIL_CYCLES = 64;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_WORDS = 2000;

    typedef struct packed {
        logic [1:0]           status;
        logic [LOC_BITS-1:0]  location;
        logic [PIDX_BITS-1:0] post_index;
    } posting_reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               cmd = CMD_CLEAR;
    logic [31:0]              delta = '0;
    logic [LOC_BITS-1:0]      target = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic [LOC_BITS-1:0]      location;
    logic [PIDX_BITS-1:0]     post_index;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_LOW_BITS;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Shadow copy of the list, the index and the registers
    logic [31:0]          list_delta [MAX_POSTS];
    bit                   idx_valid [SYNC_POINTS];
    logic [LOC_BITS-1:0]  idx_loc [SYNC_POINTS];
    logic [PIDX_BITS-1:0] idx_off [SYNC_POINTS];
    int unsigned          list_count = 0;
    logic [LOC_BITS-1:0]  run_loc = '0;
    logic [LB_BITS-1:0]   shadow_low_bits = 5'd8;
    logic [LOC_BITS-1:0]  shadow_start = '0;

    posting_reply_t pending_replies [$];
    int             answered_words = 0;
    int             fail_count = 0;
    bit             gaps_on = 1'b1;
    int             rx_hold_request = 0;

    posting_sync_index_seek_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .delta      (delta),
        .target     (target),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .location   (location),
        .post_index (post_index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Compute the reply to one word and advance the shadow state; 0 when no reply
    function automatic bit posting_reply(input logic [1:0] c, input logic [31:0] d,
                                         input logic [LOC_BITS-1:0] t,
                                         output posting_reply_t r);
        longint unsigned bucket;
        longint unsigned scan;
        longint unsigned loc;
        longint unsigned limit;
        int unsigned     first;
        int unsigned     i;
        r = '0;
        case (c)
            CMD_CLEAR:
            begin
                list_count = 0;
                foreach (idx_valid[b]) idx_valid[b] = 1'b0;
                run_loc = shadow_start;
                r.status = ST_OK;
                r.location = shadow_start;
                return 1'b1;
            end
            CMD_APPEND:
            begin
                if (list_count >= MAX_POSTS)
                begin
                    r.status = ST_FULL;
                    return 1'b1;
                end
                list_delta[list_count] = d;
                r.post_index = PIDX_BITS'(list_count);
                list_count++;
                run_loc = run_loc + d;
                r.location = run_loc;
                bucket = {32'b0, run_loc} >> shadow_low_bits;
                if (bucket >= SYNC_POINTS)
                begin
                    r.status = ST_RANGE;
                    return 1'b1;
                end
                if (!idx_valid[bucket])
                begin
                    idx_valid[bucket] = 1'b1;
                    idx_loc[bucket] = run_loc;
                    idx_off[bucket] = r.post_index;
                end
                r.status = ST_OK;
                return 1'b1;
            end
            CMD_SEEK:
            begin
                bucket = {32'b0, t} >> shadow_low_bits;
                if (bucket >= SYNC_POINTS)
                begin
                    r.status = ST_RANGE;
                    return 1'b1;
                end
                // Empty bucket: jump to the first post of the next filled one
                if (!idx_valid[bucket])
                begin
                    for (scan = bucket + 1; scan < SYNC_POINTS; scan++)
                    begin
                        if (idx_valid[scan])
                        begin
                            r.status = ST_OK;
                            r.location = idx_loc[scan];
                            r.post_index = idx_off[scan];
                            return 1'b1;
                        end
                    end
                    r.status = ST_NOT_FOUND;
                    return 1'b1;
                end
                // Filled bucket: sum deltas forward while inside the bucket
                loc = 64'(idx_loc[bucket]);
                first = 32'(idx_off[bucket]);
                limit = (bucket + 1) << shadow_low_bits;
                for (i = first; loc < limit && i < list_count && i < MAX_POSTS; i++)
                begin
                    if (i != first)
                        loc = (loc + list_delta[i]) & 64'hFFFF_FFFF;
                    if (loc >= {32'b0, t})
                    begin
                        r.status = ST_OK;
                        r.location = loc[LOC_BITS-1:0];
                        r.post_index = PIDX_BITS'(i);
                        return 1'b1;
                    end
                end
                r.status = ST_NOT_FOUND;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // Offer one word, hold it until taken, then record its reply
    task automatic send_word(input logic [1:0] c, input logic [31:0] d,
                             input logic [LOC_BITS-1:0] t);
        int             gap;
        posting_reply_t r;
        gap = (gaps_on && $urandom_range(0, 99) < 30) ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        delta <= d;
        target <= t;
        do @(posedge clk); while (!in_ready);
        if (posting_reply(c, d, t, r))
        begin
            pending_replies.push_back(r);
            answered_words++;
        end
    endtask

    // Drop valid and let the block run dry
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_LOW_BITS)
            shadow_low_bits = val[LB_BITS-1:0];
        else
            shadow_start = val;
    endtask

    task automatic configure(input logic [LB_BITS-1:0] lb, input logic [LOC_BITS-1:0] base);
        wait_idle();
        write_register(CFG_LOW_BITS, CFG_DATA_BITS'(lb));
        write_register(CFG_START, base);
    endtask

    // Reset settings, list built without a clear, every command and every status but ST_FULL
    task automatic test_directed_basics();
        send_word(CMD_SEEK, 32'd0, 32'd0);
        send_word(CMD_APPEND, 32'd0, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 32'd5, 32'd0);
        send_word(CMD_APPEND, 32'd300, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd3);
        send_word(CMD_SEEK, 32'd0, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd6);
        send_word(CMD_SEEK, 32'd0, 32'd256);
        send_word(CMD_SEEK, 32'd0, 32'd600);
        send_word(CMD_SEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 32'hFFFF_FFFF, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd304);
        send_word(CMD_APPEND, 32'h8000_0000, 32'd0);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 32'd1000, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd10);
        send_word(CMD_SEEK, 32'd0, 32'd1001);
    endtask

    // Smallest bucket size and a large one, top start location, bucket size changed under a list
    task automatic test_register_extremes();
        configure(5'd0, 32'hFFFF_FFFF);
        send_word(CMD_CLEAR, 32'd0, 32'd0);
        send_word(CMD_APPEND, 32'd1, 32'd0);
        send_word(CMD_APPEND, 32'd1023, 32'd0);
        send_word(CMD_APPEND, 32'd1, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd500);
        send_word(CMD_SEEK, 32'd0, 32'd1023);
        send_word(CMD_SEEK, 32'd0, 32'd1024);
        send_word(CMD_SEEK, 32'd0, 32'd0);
        configure(5'd4, 32'hFFFF_FFFF);
        send_word(CMD_SEEK, 32'd0, 32'd20);
        send_word(CMD_SEEK, 32'd0, 32'd5);
        send_word(CMD_APPEND, 32'd10, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd1030);
        configure(5'd24, 32'h00FF_FFF0);
        send_word(CMD_CLEAR, 32'd0, 32'd0);
        send_word(CMD_APPEND, 32'h20, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'h0100_0011);
        send_word(CMD_APPEND, 32'hFFFF_FFFF, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'h0100_000F);
        configure(5'd7, 32'h0000_0100);
        send_word(CMD_CLEAR, 32'd0, 32'd0);
        send_word(CMD_APPEND, 32'd3, 32'd0);
        send_word(CMD_SEEK, 32'd0, 32'd0);
    endtask

    // Fill every list slot, run off the index, then append to a full list
    task automatic test_list_full();
        int k;
        configure(5'd4, 32'd0);
        send_word(CMD_CLEAR, 32'd0, 32'd0);
        for (k = 0; k < MAX_POSTS + 2; k++)
            send_word(CMD_APPEND, 32'd4, $urandom);
        for (k = 0; k < 20; k++)
            send_word(CMD_SEEK, $urandom, $urandom_range(0, 16400));
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        int k;
        configure(5'd8, 32'd0);
        gaps_on = 1'b0;
        send_word(CMD_CLEAR, 32'd0, 32'd0);
        // Let the clearing pass finish so the hold lands on live results
        wait_idle();
        rx_hold_request = 400;
        for (k = 0; k < 24; k++)
        begin
            if (k % 3 == 2)
                send_word(CMD_SEEK, $urandom, $urandom_range(0, 4000));
            else
                send_word(CMD_APPEND, $urandom_range(0, 300), $urandom);
        end
        gaps_on = 1'b1;
    endtask

    // Random lists: mostly clear, appends and seeks near the list, some noise
    task automatic test_random_lists();
        int                  goal;
        int                  n_app;
        int                  n_seek;
        logic [LB_BITS-1:0]  lbv;
        logic [LOC_BITS-1:0] st;
        logic [LOC_BITS-1:0] base;
        logic [31:0]         span;
        logic [31:0]         used;
        logic [31:0]         d;
        logic [31:0]         t;
        longint unsigned     top;
        goal = answered_words + RANDOM_WORDS;
        configure(5'd8, 32'd0);
        base = shadow_start;
        while (answered_words < goal)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            // New register setting, the list is kept unless a clear follows
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 7))
                    0: lbv = 5'd0;
                    1: lbv = 5'd24;
                    default: lbv = LB_BITS'($urandom_range(1, 12));
                endcase
                top = longint'(SYNC_POINTS) << lbv;
                if (top > 64'hFFFF_FFFF)
                    top = 64'hFFFF_FFFF;
                case ($urandom_range(0, 9))
                    0: st = $urandom;
                    1, 2, 3: st = $urandom_range(0, top[31:0]);
                    default: st = $urandom_range(0, 32'd4 << lbv);
                endcase
                configure(lbv, st);
            end
            if ($urandom_range(0, 5) != 0)
            begin
                send_word(CMD_CLEAR, $urandom, $urandom);
                base = shadow_start;
            end
            span = 32'd1 << shadow_low_bits;
            n_app = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
            n_seek = $urandom_range(1, 24);
            while (n_app + n_seek > 0)
            begin
                if (n_app > 0 && (n_seek == 0 || $urandom_range(0, 2) != 0))
                begin
                    case ($urandom_range(0, 9))
                        0: d = $urandom;
                        1, 2: d = $urandom_range(0, span >> 3);
                        default: d = $urandom_range(0, 2 * span);
                    endcase
                    send_word(CMD_APPEND, d, $urandom);
                    n_app--;
                end
                else
                begin
                    used = run_loc - base;
                    case ($urandom_range(0, 9))
                        0: t = $urandom;
                        1: t = run_loc + $urandom_range(1, 4 * span);
                        2: t = base - $urandom_range(0, 2 * span);
                        default: t = base + $urandom_range(0, used);
                    endcase
                    send_word(CMD_SEEK, $urandom, t);
                    n_seek--;
                end
                if ($urandom_range(0, 24) == 0)
                    send_word(CMD_UNUSED, $urandom, $urandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold when a test asks for one
    always @(posedge clk)
    begin : receiver
        int hold_left;
        int rx_gap;
        if (rx_hold_request != 0)
        begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 99) < 25)
                rx_gap = gap_length();
        end
    end

    // Compare each taken reply with the oldest expected one
    always @(posedge clk)
    begin : check_reply
        posting_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply with no word pending: status %0d location %0h post_index %0d",
                       status, location, post_index);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
                if (location !== want.location)
                begin
                    $error("location: expected %0h actual %0h", want.location, location);
                    fail_count++;
                end
                if (post_index !== want.post_index)
                begin
                    $error("post_index: expected %0d actual %0d", want.post_index, post_index);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : run_tests
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_basics();
        test_register_extremes();
        test_list_full();
        test_backpressure();
        test_random_lists();
        // Drain the last replies, then let the block settle
        in_valid <= 1'b0;
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected replies never arrived", pending_replies.size());
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
